// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the max-subarray segment tree.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define MSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/mss_pkg.sv -----
// Shared constants for the max-subarray segment tree core.
// No dependencies.
`timescale 1ns / 1ps
package mss_pkg;
    localparam int BEST_W = 26;   // width of the reported best run sum
endpackage

// ----- design/max_subarray_segment_tree_core.sv -----
// Max-subarray segment tree core: sets one leaf per transaction and reports the best
// non-empty contiguous sum over all LEAVES leaves. Depends on mss_pkg and assert_macros.svh.
//
// An update of a leaf at depth L = $clog2(LEAVES) walks down the L levels from the root to compute
// the path, writes the leaf, and then walks back up the L levels, combining each node on the way.
// The node memory gives one read and one write per cycle to the single combine unit. The result
// waits in an output register, so a stalled result does not block the next accept; an update that
// finishes while that register is still full holds the core until it frees. A position at or
// beyond LEAVES changes nothing and presents the current best sum once the output register is
// free. After reset the core clears every node of its memory and holds o_in_stall high
// meanwhile. One transaction is in flight at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module max_subarray_segment_tree_core #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [$clog2(LEAVES)-1:0]          i_position,
    input  logic signed [VALUE_BITS-1:0]       i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mss_pkg::BEST_W-1:0]  o_best_sum
);
    localparam int POS_W = $clog2(LEAVES);
    localparam int IDX_W = POS_W + 1;
    localparam int NODES = 2 * LEAVES - 1;
    localparam int SW    = VALUE_BITS + POS_W;
    localparam int EXT_W = (SW > mss_pkg::BEST_W) ? SW : mss_pkg::BEST_W;
    localparam int D     = POS_W;
    localparam int DEP_W = $clog2(D + 1);

    typedef struct packed {
        logic signed [SW-1:0] total;
        logic signed [SW-1:0] prefix;
        logic signed [SW-1:0] suffix;
        logic signed [SW-1:0] run;
    } t_node;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             right;  // path went to the right child
        logic [IDX_W-1:0] sib;
    } t_path;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DESCEND, S_ASCEND, S_DONE} t_state;

    t_node mem [0:NODES-1];

    t_state                      r_state;
    logic [IDX_W-1:0]            r_clr;
    logic [POS_W-1:0]            r_lo, r_hi, r_target;
    logic [IDX_W-1:0]            r_idx;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [DEP_W-1:0]            r_depth;
    t_path                       r_stk [0:D];
    t_node                       r_cur;
    t_node                       r_rdata;
    logic                        r_out_valid;
    logic signed [mss_pkg::BEST_W-1:0] r_best_sum;
    logic signed [mss_pkg::BEST_W-1:0] r_root;

    logic                        w_in_acc, w_out_acc, w_in_range;
    logic                        w_desc, w_asc, w_top, w_out_free, w_post;
    logic signed [mss_pkg::BEST_W-1:0] w_post_sum;
    logic [POS_W-1:0]            w_mid;
    logic [IDX_W-1:0]            w_half, w_lc, w_rc;
    t_node                       w_leaf, w_l, w_r, w_comb;
    logic signed [SW-1:0]        w_pre, w_suf, w_mix, w_run;
    logic signed [EXT_W-1:0]     w_run_ext;
    logic                        w_we;
    logic [IDX_W-1:0]            w_waddr, w_raddr;
    t_node                       w_wdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_best_sum;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_in_range = {1'b0, i_position} < IDX_W'(LEAVES);

    // output register handoff
    assign w_desc     = (r_state == S_DESCEND);
    assign w_asc      = (r_state == S_ASCEND);
    assign w_top      = w_asc && (r_depth == DEP_W'(1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_post     = w_out_free && (w_top || (r_state == S_DONE) || (w_in_acc && !w_in_range));
    assign w_post_sum = w_top ? w_run_ext[mss_pkg::BEST_W-1:0] : r_root;

    // path step
    assign w_mid  = POS_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_half = IDX_W'(w_mid) - IDX_W'(r_lo) + IDX_W'(1);
    assign w_lc   = r_idx + IDX_W'(1);
    assign w_rc   = r_idx + (w_half << 1);

    assign w_leaf = '{total: SW'(r_val), prefix: SW'(r_val), suffix: SW'(r_val),
                      run: SW'(r_val)};

    // combine unit
    assign w_l  = r_stk[0].right ? r_rdata : r_cur;
    assign w_r  = r_stk[0].right ? r_cur : r_rdata;
    assign w_pre = w_l.total + w_r.prefix;
    assign w_suf = w_r.total + w_l.suffix;
    assign w_mix = w_l.suffix + w_r.prefix;
    assign w_run = (w_l.run > w_r.run) ? w_l.run : w_r.run;

    always_comb begin
        w_comb.total  = w_l.total + w_r.total;
        w_comb.prefix = (w_l.prefix > w_pre) ? w_l.prefix : w_pre;
        w_comb.suffix = (w_r.suffix > w_suf) ? w_r.suffix : w_suf;
        w_comb.run    = (w_run > w_mix) ? w_run : w_mix;
    end

    assign w_run_ext = EXT_W'(w_comb.run);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_leaf;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_DESCEND: begin
                w_we = (r_lo == r_hi);
            end
            S_ASCEND: begin
                w_we    = 1'b1;
                w_waddr = r_stk[0].node;
                w_wdata = w_comb;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_raddr = (r_state == S_ASCEND) ? r_stk[1].sib : r_stk[0].sib;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_best_sum  <= '0;
            r_root      <= '0;
        end else begin
            if (w_post) begin
                r_out_valid <= 1'b1;
                r_best_sum  <= w_post_sum;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_lo     <= '0;
                        r_hi     <= POS_W'(LEAVES - 1);
                        r_idx    <= '0;
                        r_target <= i_position;
                        r_val    <= i_value;
                        r_depth  <= '0;
                        if (w_in_range) begin
                            r_state <= S_DESCEND;
                        end else if (!w_out_free) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DESCEND: begin
                    if (r_lo != r_hi) begin
                        for (int i = 1; i <= D; i++) begin
                            r_stk[i] <= r_stk[i-1];
                        end
                        r_stk[0].node <= r_idx;
                        r_depth       <= r_depth + DEP_W'(1);
                        if (r_target <= w_mid) begin
                            r_stk[0].right <= 1'b0;
                            r_stk[0].sib   <= w_rc;
                            r_idx          <= w_lc;
                            r_hi           <= w_mid;
                        end else begin
                            r_stk[0].right <= 1'b1;
                            r_stk[0].sib   <= w_lc;
                            r_idx          <= w_rc;
                            r_lo           <= w_mid + POS_W'(1);
                        end
                    end else begin
                        r_cur   <= w_leaf;
                        r_state <= S_ASCEND;
                    end
                end
                S_ASCEND: begin
                    r_cur <= w_comb;
                    for (int i = 0; i < D; i++) begin
                        r_stk[i] <= r_stk[i+1];
                    end
                    r_depth <= r_depth - DEP_W'(1);
                    if (r_depth == DEP_W'(1)) begin
                        r_root  <= w_run_ext[mss_pkg::BEST_W-1:0];
                        r_state <= w_out_free ? S_IDLE : S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MSS_ASSERT(a_done_holds, i_clk, i_rst_n, (r_state == S_DONE) |-> r_out_valid, "no result")
    `MSS_ASSERT(a_depth_bound, i_clk, i_rst_n, w_desc |-> (r_depth <= DEP_W'(D)), "path too deep")
    `MSS_ASSERT(a_ascend_has_level, i_clk, i_rst_n, w_asc |-> (r_depth != '0), "empty path")
    `MSS_ASSERT(a_in_range_update, i_clk, i_rst_n, (w_in_acc && w_in_range) |=> w_desc, "no update")
    `MSS_ASSERT_ALWAYS(a_clear_blocks, i_clk, (i_rst_n && r_state == S_CLEAR) |-> (o_in_stall && !o_out_valid), "busy")
endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for max_subarray_segment_tree_core: leaf updates in, best run sum out.
// Keeps its own max-subarray segment tree to predict each result. Depends on mss_pkg and the core.
`timescale 1ns / 1ps
module tb_top;
    localparam int BEST_W      = mss_pkg::BEST_W;
    localparam int LEAVES      = 1024;
    localparam int POS_W       = $clog2(LEAVES);
    localparam int VAL_W       = 16;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} t_stall_mode;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [POS_W-1:0]         i_position  = '0;
    logic signed [VAL_W-1:0]  i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [BEST_W-1:0] o_best_sum;

    // predictor tree, heap order: node n has children 2n and 2n+1, leaves at LEAVES+pos
    longint tree_total [2*LEAVES];
    longint tree_pre   [2*LEAVES];
    longint tree_suf   [2*LEAVES];
    longint tree_run   [2*LEAVES];

    logic signed [BEST_W-1:0] expected_best [$];
    logic signed [BEST_W-1:0] want_best;
    longint                   peak_best      = -(64'sd1 <<< 40);
    int                       sent_count     = 0;
    int                       checked_count  = 0;
    int                       mismatch_count = 0;

    int                       gap_max    = 0;
    int                       burst_max  = 1;
    int                       burst_left = 0;
    t_stall_mode              stall_mode = STALL_NONE;
    logic [7:0]               stall_tick = '0;
    int                       hold_request = 0;
    int                       hold_served  = 0;
    int                       hold_left    = 0;

    max_subarray_segment_tree_core #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VAL_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_best_sum  (o_best_sum)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [BEST_W-1:0] predict_update(
            input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
        int     n;
        int     lc;
        int     rc;
        longint carry;
        longint span_mid;
        if (pos < LEAVES) begin
            n = LEAVES + int'(pos);
            tree_total[n] = val;
            tree_pre[n]   = val;
            tree_suf[n]   = val;
            tree_run[n]   = val;
            for (n = n >> 1; n >= 1; n = n >> 1) begin
                lc = 2 * n;
                rc = 2 * n + 1;
                carry = tree_total[lc] + tree_pre[rc];
                tree_pre[n] = (tree_pre[lc] > carry) ? tree_pre[lc] : carry;
                carry = tree_total[rc] + tree_suf[lc];
                tree_suf[n] = (tree_suf[rc] > carry) ? tree_suf[rc] : carry;
                span_mid = tree_suf[lc] + tree_pre[rc];
                tree_run[n] = (tree_run[lc] > tree_run[rc]) ? tree_run[lc] : tree_run[rc];
                if (span_mid > tree_run[n]) begin
                    tree_run[n] = span_mid;
                end
                tree_total[n] = tree_total[lc] + tree_total[rc];
            end
        end
        return BEST_W'(tree_run[1]);
    endfunction

    function automatic void add_expected(input logic signed [BEST_W-1:0] best);
        expected_best = {expected_best, best};
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
        end
    endtask

    // one update transaction; valid stays high across a burst
    task automatic send_update(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            end
            burst_left = $urandom_range(burst_max, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        add_expected(predict_update(pos, val));
        sent_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_best.size() != 0);
    endtask

    // receiver: long hold on request, otherwise the current stall profile
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request != hold_served) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_request;
        end else begin
            case (stall_mode)
                STALL_NONE:    i_out_stall <= 1'b0;
                STALL_LIGHT:   i_out_stall <= ($urandom_range(3, 0) == 0);
                STALL_PATTERN: i_out_stall <= stall_tick[2] & stall_tick[4];
                default:       i_out_stall <= ($urandom_range(3, 0) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_best.size() == 0) begin
                report_mismatch("result with no update pending", 0, o_best_sum);
            end else begin
                want_best = expected_best.pop_front();
                checked_count++;
                if (o_best_sum > peak_best) begin
                    peak_best = o_best_sum;
                end
                if (o_best_sum !== want_best) begin
                    report_mismatch("best_sum", want_best, o_best_sum);
                end
            end
        end
    end

    task automatic test_directed();
        gap_max    = 0;
        burst_max  = 1;
        burst_left = 0;
        stall_mode <= STALL_LIGHT;
        send_update(10'd0,    16'sh7fff);
        send_update(10'd1023, 16'sh7fff);   // peaks at both ends, zeros between
        send_update(10'd0,    16'sh8000);
        send_update(10'd1023, 16'sh8000);
        send_update(10'd511,  16'sd5);      // runs across the root split
        send_update(10'd512,  16'sd7);
        send_update(10'd510,  -16'sd3);
        send_update(10'd513,  -16'sd1);
        send_update(10'd509,  16'sd9);
        send_update(10'd514,  16'sd2);
        send_update(10'h155,  16'sh5555);
        send_update(10'h2aa,  16'shaaaa);
        send_update(10'h2aa,  16'sh2aaa);
        send_update(10'h155,  -16'sd1);
        send_update(10'h3ff,  16'sd0);
        send_update(10'd0,    16'sd0);
        send_update(10'd509,  16'sd0);
        send_update(10'd510,  16'sd0);
        send_update(10'd511,  16'sd0);
        send_update(10'd512,  16'sd0);
        send_update(10'd513,  16'sd0);
        send_update(10'd514,  16'sd0);
        send_update(10'h155,  16'sd0);
        send_update(10'h2aa,  16'sd0);
        drain_results();
    endtask

    // long positive runs drive the best sum past 2^24
    task automatic test_long_runs();
        int                      leaf;
        logic signed [VAL_W-1:0] v;
        gap_max    = 30;
        burst_max  = 8;
        burst_left = 0;
        stall_mode <= STALL_LIGHT;
        for (leaf = 0; leaf < 700; leaf++) begin
            if ($urandom_range(15, 0) == 0) begin
                v = 16'sh7fff;
            end else begin
                v = VAL_W'($urandom_range(32767, 22000));
            end
            send_update(POS_W'(leaf), v);
            if (leaf % 10 == 9) begin
                send_update(POS_W'($urandom_range(LEAVES - 1, 0)), VAL_W'($urandom()));
            end
            if (leaf == 350) begin
                stall_mode <= STALL_PATTERN;
            end
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        gap_max    = 0;
        burst_max  = 1000;
        burst_left = 0;
        stall_mode   <= STALL_NONE;
        hold_request <= hold_request + 1;
        for (k = 0; k < 40; k++) begin
            send_update(POS_W'($urandom_range(LEAVES - 1, 0)), VAL_W'($urandom()));
        end
        drain_results();
    endtask

    task automatic test_random_updates();
        int                      k;
        int                      kind;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        last_pos;
        logic signed [VAL_W-1:0] v;
        last_pos = '0;
        for (k = 0; k < 280; k++) begin
            if (k % 56 == 0) begin
                case (k / 56)
                    0: begin
                        gap_max = 0;  burst_max = 1;  stall_mode <= STALL_NONE;
                    end
                    1: begin
                        gap_max = 30; burst_max = 4;  stall_mode <= STALL_HEAVY;
                    end
                    2: begin
                        gap_max = 5;  burst_max = 20; stall_mode <= STALL_PATTERN;
                    end
                    3: begin
                        drain_results();
                        gap_max = 12; burst_max = 6;  stall_mode <= STALL_LIGHT;
                    end
                    default: begin
                        gap_max = 25; burst_max = 2;  stall_mode <= STALL_HEAVY;
                    end
                endcase
                burst_left = 0;
            end
            kind = $urandom_range(9, 0);
            pos  = POS_W'($urandom_range(LEAVES - 1, 0));
            v    = VAL_W'($urandom());
            case (kind) inside
                [4:5]: begin
                    pos = POS_W'(last_pos + $urandom_range(16, 0) - 8);
                    v   = VAL_W'(int'($urandom_range(400, 0)) - 200);
                end
                6: begin
                    case ($urandom_range(3, 0))
                        0:       v = 16'sh7fff;
                        1:       v = 16'sh8000;
                        2:       v = 16'sd0;
                        default: v = -16'sd1;
                    endcase
                end
                7:       v = VAL_W'(-int'($urandom_range(32768, 16000)));
                [8:9]:   v = VAL_W'($urandom_range(32767, 16000));
                default: ;
            endcase
            send_update(pos, v);
            last_pos = pos;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_long_runs();
        test_output_backpressure();
        test_random_updates();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_best.size() != 0);
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d leaf updates with %0d results checked under mixed stalls;",
                 sent_count, checked_count);
        $display("largest best sum observed: %0d", peak_best);
        if (mismatch_count == 0) begin
            $display("** max_subarray_segment_tree_core: PASSED **");
        end else begin
            $display("** max_subarray_segment_tree_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_best.size());
        $display("** max_subarray_segment_tree_core: FAILED **");
        $finish;
    end
endmodule
